// ===== rtl/graph_coloring_move_evaluator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// graph coloring move evaluator - assertion macros
// shared concurrent assertion forms for the evaluator rtl
// ----------------------------------------------------------------------------
`ifndef GRAPH_COLORING_MOVE_EVALUATOR_UNIT_MACROS_SVH
`define GRAPH_COLORING_MOVE_EVALUATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GCME_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GCME_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gcme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcme_pkg
// shared widths, codes and default sizes of the graph coloring move evaluator
// ----------------------------------------------------------------------------
package gcme_pkg;

   // payload field widths
   localparam int OP_W      = 2;
   localparam int VTX_W     = 6;
   localparam int COLOR_W   = 2;
   localparam int SCORE_W   = 10;
   localparam int CONF_W    = 10;
   localparam int DIST_W    = 3;
   localparam int STATUS_W  = 2;

   // configuration port
   localparam int CFG_W        = 7;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam logic [0:0] REG_NUM_VERTICES = 1'b0;

   // default sizes
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;
   localparam int NUM_COLORS_DEF   = 4;
   localparam int NV_RESET_DEF     = 64;

   // width used for range compares
   localparam int CMP_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_EDGE  = 2'd0,
      OP_SET_COLOR = 2'd1,
      OP_PROPOSE   = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

// ===== rtl/gcme_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcme_if
// request and response channels of the graph coloring move evaluator
// ----------------------------------------------------------------------------

// request channel: one operation per beat
interface gcme_req_if;
   import gcme_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [VTX_W-1:0]   vertex_a;
   logic [VTX_W-1:0]   vertex_b;
   logic [COLOR_W-1:0] new_color;

   modport source (output valid, op, vertex_a, vertex_b, new_color, input ready);
   modport sink   (input valid, op, vertex_a, vertex_b, new_color, output ready);
endinterface

// response channel: one result per beat
interface gcme_rsp_if;
   import gcme_pkg::*;

   logic                valid;
   logic                ready;
   logic [SCORE_W-1:0]  score;
   logic [CONF_W-1:0]   conflicts;
   logic [DIST_W-1:0]   distinct_colors;
   logic                accepted;
   logic [STATUS_W-1:0] status;

   modport source (output valid, score, conflicts, distinct_colors, accepted, status,
                   input ready);
   modport sink   (input valid, score, conflicts, distinct_colors, accepted, status,
                   output ready);
endinterface

// ===== rtl/graph_coloring_move_evaluator_unit.sv =====
`timescale 1ns / 1ps
`include "graph_coloring_move_evaluator_unit_macros.svh"
// ----------------------------------------------------------------------------
// graph_coloring_move_evaluator_unit
// Keeps an edge list and a color per vertex and scores the coloring as twice
// the conflicting edges plus the number of colors in use. One operation is
// handled at a time. Add edge passes through the lookup and fetch states to
// its result; set color and propose move go on to a walk over the edge memory
// at one edge per cycle; clear colors sweeps the color memory one entry per
// cycle before the edge walk. A num_vertices write starts a recount, a tally
// over the vertices in use and then an edge walk, during which no request is
// taken. After reset a clearing pass over all MAX_VERTICES entries zeroes the
// color memory before the first request is taken. A finished result waits in
// an output register, and the next request may be taken while it waits.
// ----------------------------------------------------------------------------
module graph_coloring_move_evaluator_unit #(
   parameter int MAX_VERTICES = gcme_pkg::MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = gcme_pkg::MAX_EDGES_DEF,
   parameter int NUM_COLORS   = gcme_pkg::NUM_COLORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gcme_req_if.sink                        req_ch,
   gcme_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gcme_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gcme_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gcme_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import gcme_pkg::*;

   localparam int VW       = $clog2(MAX_VERTICES);
   localparam int NVW      = $clog2(MAX_VERTICES + 1);
   localparam int ECW      = $clog2(MAX_EDGES + 1);
   localparam int EAW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CLRW     = $clog2(NUM_COLORS);
   localparam int TW       = NVW;
   localparam int DW       = $clog2(NUM_COLORS + 1);
   localparam int CFW      = $clog2(2 * MAX_EDGES + 1);
   localparam int SCW      = ((CFW > DW) ? CFW : DW) + 1;
   localparam int NV_RESET = (NV_RESET_DEF > MAX_VERTICES) ? MAX_VERTICES : NV_RESET_DEF;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_FETCH,
      S_TALLY,
      S_WALK,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      W_PLAIN,
      W_SUBST,
      W_ALL_EQ
   } walk_mode_type;

   typedef logic [TW-1:0] tally_arr_type [NUM_COLORS];

   // number of colors with a nonzero tally
   function automatic logic [DW-1:0] count_distinct(input tally_arr_type t);
      logic [DW-1:0] n;
      n = '0;
      for (int k = 0; k < NUM_COLORS; k++) begin
         if (t[k] != '0) begin
            n = DW'(n + 1'b1);
         end
      end
      return n;
   endfunction

   // registers
   state_type       state_ff, state_in;
   walk_mode_type   mode_ff, mode_in;
   logic [NVW-1:0]  nv_ff, nv_in;
   logic            pend_ff, pend_in;
   logic            item_ff, item_in;
   op_type          op_ff, op_in;
   logic [VW-1:0]   va_ff, va_in;
   logic [VW-1:0]   vb_ff, vb_in;
   logic [CLRW-1:0] col_ff, col_in;
   logic [CLRW-1:0] old_ff, old_in;
   logic [NVW-1:0]  vidx_ff, vidx_in;
   logic [ECW-1:0]  eidx_ff, eidx_in;
   logic [ECW-1:0]  edge_cnt_ff, edge_cnt_in;
   tally_arr_type   tally_ff, tally_in;
   logic [CFW-1:0]  conf_ff, conf_in;
   logic [CFW-1:0]  acc_ff, acc_in;
   logic            p1_ff, p1_in;
   logic            p2_ff, p2_in;
   logic            t1_ff, t1_in;
   logic [VW-1:0]   ea_ff, ea_in;
   logic [VW-1:0]   eb_ff, eb_in;
   status_type      status_ff, status_in;
   logic            accepted_ff, accepted_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [CONF_W-1:0]  rsp_conf_ff, rsp_conf_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic               rsp_acc_ff, rsp_acc_in;
   status_type         rsp_status_ff, rsp_status_in;

   // memory ports
   logic              col_we;
   logic [VW-1:0]     col_waddr;
   logic [CLRW-1:0]   col_wdata;
   logic [VW-1:0]     col_raddr_a, col_raddr_b;
   logic [CLRW-1:0]   col_rd_a, col_rd_b;
   logic              edge_we;
   logic [EAW-1:0]    edge_waddr;
   logic [2*VW-1:0]   edge_wdata;
   logic [2*VW-1:0]   edge_rd;

   // combinational helpers
   logic              csr_wr;
   logic [CMP_W-1:0]  wv16;
   logic [CMP_W-1:0]  nv16;
   logic [CMP_W-1:0]  c16;
   logic              req_ready;
   logic              req_fire;
   op_type            in_op;
   logic              a_bad, b_bad, range_err, full_err;
   logic              e_issue, v_issue, walk_done;
   logic [CLRW-1:0]   ca, cb;
   logic              ina, inb, eq;
   logic [1:0]        inc;
   tally_arr_type     nt;
   logic [DW-1:0]     dist_cur, dist_new;
   logic [SCW-1:0]    score_cur, score_new;
   logic              commit;
   logic [NVW-1:0]    tally_sum;

   // color memory, one copy per read port, written together
   gcme_ram #(.WIDTH(CLRW), .DEPTH(MAX_VERTICES)) u_color_a (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_addr (col_raddr_a),
      .rd_data (col_rd_a)
   );

   gcme_ram #(.WIDTH(CLRW), .DEPTH(MAX_VERTICES)) u_color_b (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_addr (col_raddr_b),
      .rd_data (col_rd_b)
   );

   // edge memory, entry holds {end a, end b}
   gcme_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edges (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (edge_waddr),
      .wr_data (edge_wdata),
      .rd_addr (eidx_ff[EAW-1:0]),
      .rd_data (edge_rd)
   );

   // configuration port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_NUM_VERTICES) ?
                       CSR_DATA_W'(nv_ff) : '0;
   assign wv16       = CMP_W'(csr_pwdata[CFG_W-1:0]);

   // request side
   assign req_ready    = (state_ff == S_IDLE) && !pend_ff && !csr_wr;
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign in_op        = op_type'(req_ch.op);
   assign nv16         = CMP_W'(nv_ff);
   assign a_bad        = CMP_W'(req_ch.vertex_a) >= nv16;
   assign b_bad        = CMP_W'(req_ch.vertex_b) >= nv16;
   assign c16          = CMP_W'(req_ch.new_color);

   // response side
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.score           = rsp_score_ff;
   assign rsp_ch.conflicts       = rsp_conf_ff;
   assign rsp_ch.distinct_colors = rsp_dist_ff;
   assign rsp_ch.accepted        = rsp_acc_ff;
   assign rsp_ch.status          = rsp_status_ff;

   // error checks on the incoming item
   always_comb begin
      case (in_op)
         OP_ADD_EDGE:               range_err = a_bad || b_bad;
         OP_SET_COLOR, OP_PROPOSE:  range_err = a_bad;
         default:                   range_err = 1'b0;
      endcase
      full_err = (in_op == OP_ADD_EDGE) && (edge_cnt_ff == ECW'(MAX_EDGES));
   end

   // walk pipeline: edge read, color reads, compare and accumulate
   assign e_issue   = (state_ff == S_WALK) && (eidx_ff < edge_cnt_ff);
   assign v_issue   = (state_ff == S_TALLY) && (vidx_ff < nv_ff);
   assign walk_done = (state_ff == S_WALK) && !e_issue && !p1_ff && !p2_ff;

   always_comb begin
      ca  = ((mode_ff == W_SUBST) && (ea_ff == va_ff)) ? col_ff : col_rd_a;
      cb  = ((mode_ff == W_SUBST) && (eb_ff == va_ff)) ? col_ff : col_rd_b;
      eq  = (mode_ff == W_ALL_EQ) || (ca == cb);
      ina = CMP_W'(ea_ff) < nv16;
      inb = CMP_W'(eb_ff) < nv16;
      inc = eq ? (2'(ina) + 2'(inb)) : 2'd0;
   end

   // tally after a tentative recolor, and the scores around it
   always_comb begin
      for (int k = 0; k < NUM_COLORS; k++) begin
         nt[k] = tally_ff[k];
         if (CLRW'(k) == old_ff) begin
            nt[k] = TW'(nt[k] - 1'b1);
         end
         if (CLRW'(k) == col_ff) begin
            nt[k] = TW'(nt[k] + 1'b1);
         end
      end
      dist_cur  = count_distinct(tally_ff);
      dist_new  = count_distinct(nt);
      score_cur = SCW'(conf_ff) + SCW'(dist_cur);
      score_new = SCW'(acc_ff) + SCW'(dist_new);
      commit    = (op_ff == OP_SET_COLOR) || (score_new <= score_cur);
   end

   // memory address and write selection
   always_comb begin
      col_raddr_a = '0;
      col_raddr_b = '0;
      case (state_ff)
         S_LOOKUP: begin
            col_raddr_a = va_ff;
            col_raddr_b = vb_ff;
         end
         S_TALLY: begin
            col_raddr_a = vidx_ff[VW-1:0];
         end
         S_WALK: begin
            col_raddr_a = edge_rd[2*VW-1:VW];
            col_raddr_b = edge_rd[VW-1:0];
         end
         default: begin
         end
      endcase

      col_we    = 1'b0;
      col_waddr = va_ff;
      col_wdata = col_ff;
      if (state_ff == S_CLEAR) begin
         col_we    = 1'b1;
         col_waddr = vidx_ff[VW-1:0];
         col_wdata = '0;
      end else if (walk_done && (mode_ff == W_SUBST) && commit) begin
         col_we = 1'b1;
      end

      edge_we    = (state_ff == S_FETCH) && (op_ff == OP_ADD_EDGE);
      edge_waddr = edge_cnt_ff[EAW-1:0];
      edge_wdata = {va_ff, vb_ff};
   end

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      nv_in         = nv_ff;
      pend_in       = pend_ff;
      item_in       = item_ff;
      op_in         = op_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      col_in        = col_ff;
      old_in        = old_ff;
      vidx_in       = vidx_ff;
      eidx_in       = eidx_ff;
      edge_cnt_in   = edge_cnt_ff;
      tally_in      = tally_ff;
      conf_in       = conf_ff;
      acc_in        = acc_ff;
      p1_in         = 1'b0;
      p2_in         = 1'b0;
      t1_in         = 1'b0;
      ea_in         = ea_ff;
      eb_in         = eb_ff;
      status_in     = status_ff;
      accepted_in   = accepted_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_score_in  = rsp_score_ff;
      rsp_conf_in   = rsp_conf_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         // sweep zeros through the color memory
         S_CLEAR: begin
            vidx_in = NVW'(vidx_ff + 1'b1);
            if (vidx_ff == NVW'(MAX_VERTICES - 1)) begin
               for (int k = 0; k < NUM_COLORS; k++) begin
                  tally_in[k] = '0;
               end
               tally_in[0] = TW'(nv_ff);
               mode_in     = W_ALL_EQ;
               eidx_in     = '0;
               acc_in      = '0;
               state_in    = S_WALK;
            end
         end

         S_IDLE: begin
            if (pend_ff) begin
               // recount after a num_vertices write
               pend_in = 1'b0;
               item_in = 1'b0;
               vidx_in = '0;
               for (int k = 0; k < NUM_COLORS; k++) begin
                  tally_in[k] = '0;
               end
               state_in = S_TALLY;
            end else if (req_fire) begin
               op_in       = in_op;
               va_in       = VW'(req_ch.vertex_a);
               vb_in       = VW'(req_ch.vertex_b);
               col_in      = CLRW'((c16 >= CMP_W'(NUM_COLORS)) ?
                                   c16 - CMP_W'(NUM_COLORS) : c16);
               item_in     = 1'b1;
               accepted_in = 1'b0;
               status_in   = ST_OK;
               if (range_err) begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end else if (full_err) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else if (in_op == OP_CLEAR) begin
                  vidx_in  = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end

         S_LOOKUP: begin
            state_in = S_FETCH;
         end

         // colors of the item's vertices are on the read ports
         S_FETCH: begin
            if (op_ff == OP_ADD_EDGE) begin
               if (col_rd_a == col_rd_b) begin
                  conf_in = CFW'(conf_ff + 2'd2);
               end
               edge_cnt_in = ECW'(edge_cnt_ff + 1'b1);
               state_in    = S_DONE;
            end else begin
               old_in   = col_rd_a;
               mode_in  = W_SUBST;
               eidx_in  = '0;
               acc_in   = '0;
               state_in = S_WALK;
            end
         end

         // per-color tally over the vertices in use
         S_TALLY: begin
            t1_in = v_issue;
            if (v_issue) begin
               vidx_in = NVW'(vidx_ff + 1'b1);
            end
            if (t1_ff) begin
               tally_in[col_rd_a] = TW'(tally_ff[col_rd_a] + 1'b1);
            end
            if (!v_issue && !t1_ff) begin
               mode_in  = W_PLAIN;
               eidx_in  = '0;
               acc_in   = '0;
               state_in = S_WALK;
            end
         end

         // conflict count over the stored edges
         S_WALK: begin
            p1_in = e_issue;
            p2_in = p1_ff;
            if (e_issue) begin
               eidx_in = ECW'(eidx_ff + 1'b1);
            end
            if (p1_ff) begin
               ea_in = edge_rd[2*VW-1:VW];
               eb_in = edge_rd[VW-1:0];
            end
            if (p2_ff) begin
               acc_in = CFW'(acc_ff + inc);
            end
            if (walk_done) begin
               if (mode_ff == W_SUBST) begin
                  if (commit) begin
                     tally_in    = nt;
                     conf_in     = acc_ff;
                     accepted_in = (op_ff == OP_PROPOSE);
                  end
               end else begin
                  conf_in = acc_ff;
               end
               state_in = item_ff ? S_DONE : S_IDLE;
            end
         end

         // hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_score_in  = SCORE_W'(score_cur);
               rsp_conf_in   = CONF_W'(conf_ff);
               rsp_dist_in   = DIST_W'(dist_cur);
               rsp_acc_in    = accepted_ff;
               rsp_status_in = status_ff;
               item_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // num_vertices write, clamped into range
      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_NUM_VERTICES)) begin
         if (wv16 == '0) begin
            nv_in = NVW'(1);
         end else if (wv16 > CMP_W'(MAX_VERTICES)) begin
            nv_in = NVW'(MAX_VERTICES);
         end else begin
            nv_in = NVW'(wv16);
         end
         pend_in = 1'b1;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      col_ff        <= col_in;
      old_ff        <= old_in;
      acc_ff        <= acc_in;
      ea_ff         <= ea_in;
      eb_ff         <= eb_in;
      status_ff     <= status_in;
      accepted_ff   <= accepted_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_conf_ff   <= rsp_conf_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= W_ALL_EQ;
         nv_ff        <= NVW'(NV_RESET);
         pend_ff      <= 1'b0;
         item_ff      <= 1'b0;
         vidx_ff      <= '0;
         eidx_ff      <= '0;
         edge_cnt_ff  <= '0;
         for (int k = 0; k < NUM_COLORS; k++) begin
            tally_ff[k] <= '0;
         end
         conf_ff      <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         t1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         nv_ff        <= nv_in;
         pend_ff      <= pend_in;
         item_ff      <= item_in;
         vidx_ff      <= vidx_in;
         eidx_ff      <= eidx_in;
         edge_cnt_ff  <= edge_cnt_in;
         tally_ff     <= tally_in;
         conf_ff      <= conf_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         t1_ff        <= t1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sum of tallies, checked against num_vertices
   always_comb begin
      tally_sum = '0;
      for (int k = 0; k < NUM_COLORS; k++) begin
         tally_sum = NVW'(tally_sum + tally_ff[k]);
      end
   end

   `GCME_ASSERT_IMP(a_edge_bound, clock, reset, 1'b1, edge_cnt_ff <= ECW'(MAX_EDGES), "edge count past capacity")
   `GCME_ASSERT_IMP(a_tally_sum, clock, reset, (state_ff == S_IDLE) && !pend_ff, tally_sum == nv_ff, "color tallies do not add up to num_vertices")
   `GCME_ASSERT_IMP(a_walk_idx, clock, reset, state_ff == S_WALK, eidx_ff <= edge_cnt_ff, "edge walk ran past the edge count")
   `GCME_ASSERT_IMP(a_accept_ok, clock, reset, rsp_valid_ff && rsp_acc_ff, rsp_status_ff == ST_OK, "kept move reported with error status")
   `GCME_ASSERT_NXT(a_busy_after_beat, clock, reset, req_ch.valid && req_ch.ready, state_ff != S_IDLE, "request beat did not start work")

endmodule

// ===== rtl/gcme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcme_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module gcme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_graph_coloring_move_evaluator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_coloring_move_evaluator_unit
// Self-checking bench for the graph coloring move evaluator. Operations go in
// through the request channel and a local model of the coloring state works
// out the result of each accepted beat. Every response beat is checked field
// by field against the oldest pending result. The run moves through several
// num_vertices settings, keeps adding edges until the store is full, leaves
// random gaps between requests and puts random back-pressure on responses.
// ----------------------------------------------------------------------------
module tb_graph_coloring_move_evaluator_unit;
   import gcme_pkg::*;

   localparam int MAX_V    = MAX_VERTICES_DEF;
   localparam int MAX_E    = MAX_EDGES_DEF;
   localparam int N_COLORS = NUM_COLORS_DEF;

   typedef struct packed {
      op_type             op;
      logic [VTX_W-1:0]   va;
      logic [VTX_W-1:0]   vb;
      logic [COLOR_W-1:0] color;
   } gc_op_t;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [CONF_W-1:0]  conflicts;
      logic [DIST_W-1:0]  n_colors;
      logic               accepted;
      status_type         status;
   } gc_result_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   gcme_req_if req_bus ();
   gcme_rsp_if rsp_bus ();

   graph_coloring_move_evaluator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // model of the coloring state
   logic [COLOR_W-1:0] color_of [MAX_V];
   logic [VTX_W-1:0]   edge_a [MAX_E];
   logic [VTX_W-1:0]   edge_b [MAX_E];
   int unsigned        n_edges;
   int unsigned        vtx_in_use;
   int unsigned        pair_conflicts;
   int unsigned        colors_seen;

   // stimulus and checking bookkeeping
   gc_op_t      op_queue [$];
   gc_result_t  score_queue [$];
   int unsigned ops_sent;
   int unsigned results_seen;
   int unsigned mismatch_count;
   int unsigned tx_idle_pct;
   int unsigned rx_idle_pct;
   gc_op_t      launch_op;
   gc_op_t      seen_op;
   gc_result_t  want;

   // recount color tallies and doubled conflicts from scratch
   function automatic void rebuild_totals();
      int unsigned tally [N_COLORS];
      int unsigned c;
      c = 0;
      for (int k = 0; k < N_COLORS; k++) tally[k] = 0;
      for (int i = 0; i < MAX_V; i++)
         if (i < vtx_in_use) tally[color_of[i]]++;
      for (int i = 0; i < MAX_E; i++) begin
         if (i < n_edges && color_of[edge_a[i]] == color_of[edge_b[i]]) begin
            if (edge_a[i] < vtx_in_use) c++;
            if (edge_b[i] < vtx_in_use) c++;
         end
      end
      pair_conflicts = c;
      colors_seen = 0;
      for (int k = 0; k < N_COLORS; k++)
         if (tally[k] != 0) colors_seen++;
   endfunction

   // apply one operation to the model and return the score it leaves
   function automatic gc_result_t evaluate_op(input gc_op_t it);
      gc_result_t         r;
      int unsigned        prior;
      logic [COLOR_W-1:0] old_color;
      r.accepted = 1'b0;
      r.status   = ST_OK;
      case (it.op)
         OP_ADD_EDGE: begin
            if (it.va >= vtx_in_use || it.vb >= vtx_in_use) begin
               r.status = ST_RANGE;
            end else if (n_edges >= MAX_E) begin
               r.status = ST_FULL;
            end else begin
               edge_a[n_edges] = it.va;
               edge_b[n_edges] = it.vb;
               n_edges++;
               rebuild_totals();
            end
         end
         OP_SET_COLOR: begin
            if (it.va >= vtx_in_use) begin
               r.status = ST_RANGE;
            end else begin
               color_of[it.va] = it.color;
               rebuild_totals();
            end
         end
         OP_PROPOSE: begin
            if (it.va >= vtx_in_use) begin
               r.status = ST_RANGE;
            end else begin
               // keep the move unless the score goes up
               prior     = pair_conflicts + colors_seen;
               old_color = color_of[it.va];
               color_of[it.va] = it.color;
               rebuild_totals();
               if (pair_conflicts + colors_seen > prior) begin
                  color_of[it.va] = old_color;
                  rebuild_totals();
               end else begin
                  r.accepted = 1'b1;
               end
            end
         end
         default: begin
            for (int i = 0; i < MAX_V; i++) color_of[i] = '0;
            rebuild_totals();
         end
      endcase
      r.conflicts = pair_conflicts[CONF_W-1:0];
      r.n_colors  = colors_seen[DIST_W-1:0];
      r.score     = SCORE_W'(pair_conflicts + colors_seen);
      return r;
   endfunction

   // queue one operation for the driver
   task automatic push_op(input op_type op, input int va, input int vb, input int col);
      gc_op_t it;
      it.op    = op;
      it.va    = va[VTX_W-1:0];
      it.vb    = vb[VTX_W-1:0];
      it.color = col[COLOR_W-1:0];
      op_queue.insert(op_queue.size(), it);
      ops_sent++;
   endtask

   // write num_vertices through the csr port, then mirror it in the model
   task automatic csr_write(input logic [CSR_DATA_W-1:0] wdata);
      int unsigned v;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_NUM_VERTICES, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      v = 32'(wdata[CFG_W-1:0]);
      if (v < 1) v = 1;
      if (v > MAX_V) v = MAX_V;
      vtx_in_use = v;
      rebuild_totals();
   endtask

   // block until every queued operation has had its result checked
   task automatic wait_drained();
      do @(posedge clock); while (results_seen != ops_sent);
   endtask

   task automatic check_field(input string fname, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch expected %0d actual %0d", $time, fname, exp_v, act_v);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            launch_op = op_queue.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.op        <= launch_op.op;
            req_bus.vertex_a  <= launch_op.va;
            req_bus.vertex_b  <= launch_op.vb;
            req_bus.new_color <= launch_op.color;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
   end

   // monitor: check response beats, then predict accepted request beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (score_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat expected none actual score %0d", $time,
                        rsp_bus.score);
            end else begin
               want = score_queue.pop_front();
               check_field("score", 16'(want.score), 16'(rsp_bus.score));
               check_field("conflicts", 16'(want.conflicts), 16'(rsp_bus.conflicts));
               check_field("distinct_colors", 16'(want.n_colors),
                           16'(rsp_bus.distinct_colors));
               check_field("accepted", 16'(want.accepted), 16'(rsp_bus.accepted));
               check_field("status", 16'(want.status), 16'(rsp_bus.status));
               results_seen++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen_op.op    = op_type'(req_bus.op);
            seen_op.va    = req_bus.vertex_a;
            seen_op.vb    = req_bus.vertex_b;
            seen_op.color = req_bus.new_color;
            score_queue.insert(score_queue.size(), evaluate_op(seen_op));
         end
      end
   end

   // run limit
   initial begin
      #8000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // main sequence
   initial begin
      logic [CSR_DATA_W-1:0] wvals [8];
      int unsigned           planned;
      int unsigned           roll;
      int                    va;
      int                    vb;
      op_type                sel;
      wvals = '{32'd64, 32'd127, 32'd17, 32'd40, 32'h0000_0381, 32'd64, 32'd9, 32'd64};

      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.op        = '0;
      req_bus.vertex_a  = '0;
      req_bus.vertex_b  = '0;
      req_bus.new_color = '0;
      rsp_bus.ready     = 1'b0;
      tx_idle_pct       = 21;
      rx_idle_pct       = 79;
      ops_sent          = 0;
      results_seen      = 0;
      mismatch_count    = 0;

      // model reset state
      for (int i = 0; i < MAX_V; i++) color_of[i] = '0;
      n_edges    = 0;
      vtx_in_use = NV_RESET_DEF;
      rebuild_totals();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: moves, self-loop and duplicate edges at full size
      push_op(OP_PROPOSE, 0, 0, 3);
      push_op(OP_SET_COLOR, 63, 0, 3);
      push_op(OP_SET_COLOR, 0, 0, 3);
      push_op(OP_ADD_EDGE, 0, 63, 0);
      push_op(OP_ADD_EDGE, 7, 7, 0);
      push_op(OP_ADD_EDGE, 0, 63, 0);
      push_op(OP_PROPOSE, 63, 0, 0);
      push_op(OP_PROPOSE, 7, 0, 2);
      push_op(OP_SET_COLOR, 0, 0, 1);
      push_op(OP_PROPOSE, 0, 0, 2);
      push_op(OP_CLEAR, 63, 63, 3);
      push_op(OP_ADD_EDGE, 62, 1, 0);
      wait_drained();

      // directed: vertex range errors, edges with ends out of use
      csr_write(32'd3);
      push_op(OP_ADD_EDGE, 3, 0, 0);
      push_op(OP_ADD_EDGE, 0, 3, 0);
      push_op(OP_ADD_EDGE, 63, 63, 3);
      push_op(OP_SET_COLOR, 3, 0, 1);
      push_op(OP_PROPOSE, 63, 0, 2);
      push_op(OP_CLEAR, 0, 0, 0);
      push_op(OP_SET_COLOR, 2, 0, 3);
      push_op(OP_PROPOSE, 1, 0, 3);
      push_op(OP_ADD_EDGE, 2, 1, 0);
      wait_drained();

      // directed: zero register value taken as one vertex
      csr_write(32'd0);
      push_op(OP_SET_COLOR, 0, 0, 2);
      push_op(OP_ADD_EDGE, 1, 0, 0);
      push_op(OP_PROPOSE, 0, 0, 1);
      wait_drained();

      // random phases, edge adds weighted until the store fills
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            tx_idle_pct = 79;
            rx_idle_pct = 21;
         end
         if (ph == 6) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         csr_write(wvals[ph]);
         planned = n_edges;
         for (int k = 0; k < 90; k++) begin
            roll = $urandom_range(99);
            if (planned < MAX_E)
               sel = roll < 50 ? OP_ADD_EDGE : roll < 65 ? OP_SET_COLOR :
                     roll < 95 ? OP_PROPOSE : OP_CLEAR;
            else
               sel = roll < 10 ? OP_ADD_EDGE : roll < 35 ? OP_SET_COLOR :
                     roll < 92 ? OP_PROPOSE : OP_CLEAR;
            // mostly vertices in use, some anywhere in the field
            va = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(vtx_in_use - 1);
            vb = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(vtx_in_use - 1);
            if (sel == OP_ADD_EDGE && va < vtx_in_use && vb < vtx_in_use) planned++;
            push_op(sel, va, vb, $urandom_range(3));
         end
         wait_drained();
      end

      // let any stray beat show up before the verdict
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
